>>> design/awsf_pkg.sv
// ----------------------------------------------------------------------------
// awsf_pkg
// Shared types and constants for the ALU with status flags: opcodes,
// sequencer states and the control bundle driven into the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

package awsf_pkg;

  // width of the operand and result ports
  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBC = 4'd3,
    OP_MUL = 4'd4,
    OP_DIV = 4'd5,
    OP_AND = 4'd6,
    OP_ORR = 4'd7,
    OP_EOR = 4'd8,
    OP_MVN = 4'd9,
    OP_BIC = 4'd10,
    OP_ASR = 4'd11,
    OP_LSL = 4'd12,
    OP_LSR = 4'd13,
    OP_ROR = 4'd14,
    OP_RRX = 4'd15
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    start;
    logic    step;
    opcode_e op;
    logic    cin;
  } unit_ctrl_t;

endpackage

`default_nettype wire

>>> design/awsf_unit.sv
// ----------------------------------------------------------------------------
// awsf_unit
// Shared adder with its iteration registers. Adds and subtracts in one
// pass, multiplies by shift-and-add and divides by restoring division,
// one bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module awsf_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire awsf_pkg::unit_ctrl_t ctrl_i,
  input  wire [DATA_WIDTH-1:0]   a_i,
  input  wire [DATA_WIDTH-1:0]   b_i,
  output logic [DATA_WIDTH-1:0]  sum_o,
  output logic                   carry_o,
  output logic [DATA_WIDTH-1:0]  prod_o,
  output logic [DATA_WIDTH-1:0]  quo_o
);
  import awsf_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] sh_q, sh_d;
  logic [W-1:0] mc_q, mc_d;

  logic [W:0]   add_x;
  logic [W:0]   add_y;
  logic         add_cin;
  logic [W+1:0] add_sum;

  // operand select for the one adder
  always_comb begin
    add_x   = {1'b0, a_i};
    add_y   = {1'b0, b_i};
    add_cin = 1'b0;
    if (ctrl_i.step && (ctrl_i.op == OP_MUL)) begin
      add_x = {1'b0, acc_q};
      add_y = {1'b0, mc_q};
    end else if (ctrl_i.step) begin
      // trial subtract of the divisor from the shifted remainder
      add_x   = {acc_q, sh_q[W-1]};
      add_y   = ~{1'b0, b_i};
      add_cin = 1'b1;
    end else begin
      case (ctrl_i.op)
        OP_ADD: begin
          add_cin = 1'b0;
        end
        OP_ADC: begin
          add_cin = ctrl_i.cin;
        end
        OP_SUB: begin
          add_y   = ~{1'b0, b_i};
          add_cin = 1'b1;
        end
        OP_SBC: begin
          add_y   = ~{1'b0, b_i};
          add_cin = ctrl_i.cin;
        end
        default: begin
          add_cin = 1'b0;
        end
      endcase
    end
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};

  assign sum_o   = add_sum[W-1:0];
  // true carry for add, not-borrow for subtract
  assign carry_o = ((ctrl_i.op == OP_ADD) || (ctrl_i.op == OP_ADC)) ? add_sum[W] : add_sum[W+1];
  assign prod_o  = acc_q;
  assign quo_o   = sh_q;

  always_comb begin
    acc_d = acc_q;
    sh_d  = sh_q;
    mc_d  = mc_q;
    if (ctrl_i.start) begin
      acc_d = '0;
      sh_d  = (ctrl_i.op == OP_MUL) ? b_i : a_i;
      mc_d  = a_i;
    end else if (ctrl_i.step && (ctrl_i.op == OP_MUL)) begin
      if (sh_q[0]) begin
        acc_d = add_sum[W-1:0];
      end
      mc_d = {mc_q[W-2:0], 1'b0};
      sh_d = {1'b0, sh_q[W-1:1]};
    end else if (ctrl_i.step) begin
      acc_d = add_sum[W+1] ? add_sum[W-1:0] : {acc_q[W-2:0], sh_q[W-1]};
      sh_d  = {sh_q[W-2:0], add_sum[W+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sh_q  <= '0;
      mc_q  <= '0;
    end else begin
      acc_q <= acc_d;
      sh_q  <= sh_d;
      mc_q  <= mc_d;
    end
  end

endmodule

`default_nettype wire

>>> design/awsf_shift.sv
// ----------------------------------------------------------------------------
// awsf_shift
// Logic operations, barrel shifts, rotate and rotate through carry.
// Shift amount is the low byte of operand b.
// ----------------------------------------------------------------------------
`default_nettype none

module awsf_shift #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire awsf_pkg::opcode_e op_i,
  input  wire [DATA_WIDTH-1:0]   a_i,
  input  wire [DATA_WIDTH-1:0]   b_i,
  input  wire                    cin_i,
  output logic [DATA_WIDTH-1:0]  result_o
);
  import awsf_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned KW   = $clog2(DATA_WIDTH);
  localparam int unsigned NAMT = 256;

  logic [7:0]     amt;
  logic [KW-1:0]  rot_tab [NAMT];
  logic [KW-1:0]  rot_k;
  logic [2*W-1:0] rot_w;

  assign amt = b_i[7:0];

  // rotate amount modulo the word width, fixed at elaboration
  for (genvar gi = 0; gi < NAMT; gi++) begin : g_rot
    assign rot_tab[gi] = KW'(gi % DATA_WIDTH);
  end

  assign rot_k = rot_tab[amt];
  assign rot_w = {a_i, a_i} >> rot_k;

  always_comb begin
    case (op_i)
      OP_AND:  result_o = a_i & b_i;
      OP_ORR:  result_o = a_i | b_i;
      OP_EOR:  result_o = a_i ^ b_i;
      OP_MVN:  result_o = ~a_i;
      OP_BIC:  result_o = a_i & ~b_i;
      OP_ASR:  result_o = W'($signed(a_i) >>> amt);
      OP_LSL:  result_o = a_i << amt;
      OP_LSR:  result_o = a_i >> amt;
      OP_ROR:  result_o = rot_w[W-1:0];
      OP_RRX:  result_o = {cin_i, a_i[W-1:1]};
      default: result_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/alu_with_status_flags_core.sv
// ----------------------------------------------------------------------------
// alu_with_status_flags_core
// ALU with N, Z and C flags. Multiply and divide iterate on a shared adder,
// everything else finishes in one pass.
//
//   channel  direction  signals
//   in       sink       in_valid_i, in_stall_o, opcode_i, operand_a_i,
//                       operand_b_i, update_flags_i
//   out      source     out_valid_o, out_stall_i, result_word_o,
//                       negative_out_o, zero_out_o, carry_out_o
//
// mul and div go through the accept in ST_IDLE, one adder step per product or quotient
// bit in ST_RUN and the finish into the result register in ST_DONE, then back to
// ST_IDLE for the next accept. Other ops go from the accept straight to the finish.
// One item is in flight; a new item is taken while a result still waits.
// The finish step holds while the output register is full and stalled.
// Reset clears the flags, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_with_status_flags_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire [3:0]                   opcode_i,
  input  wire [awsf_pkg::WORD_W-1:0]  operand_a_i,
  input  wire [awsf_pkg::WORD_W-1:0]  operand_b_i,
  input  wire                         update_flags_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [awsf_pkg::WORD_W-1:0] result_word_o,
  output logic                        negative_out_o,
  output logic                        zero_out_o,
  output logic                        carry_out_o
);
  import awsf_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned CNTW = $clog2(DATA_WIDTH);

  state_e         state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  opcode_e        op_q;
  logic [W-1:0]   a_q, b_q;
  logic           upd_q;

  logic           n_q, z_q, c_q;
  logic           out_valid_q;
  logic [WORD_W-1:0] res_q;

  logic           in_xfer;
  logic           out_free;
  logic           do_start;
  logic           do_step;
  logic           do_finish;
  logic           iterative;

  unit_ctrl_t     ctrl;
  logic [W-1:0]   sum;
  logic           add_carry;
  logic [W-1:0]   prod;
  logic [W-1:0]   quo;
  logic [W-1:0]   sh_res;
  logic [W-1:0]   res;
  logic           new_c;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign iterative = (opcode_e'(opcode_i) == OP_MUL) || (opcode_e'(opcode_i) == OP_DIV);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = iterative ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(DATA_WIDTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    do_step    = 1'b0;
    do_finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        do_step = 1'b1;
      end
      ST_DONE: begin
        do_finish = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign do_start = in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= opcode_e'(opcode_i);
      a_q   <= W'(operand_a_i);
      b_q   <= W'(operand_b_i);
      upd_q <= update_flags_i;
    end
  end

  always_comb begin
    ctrl.start = do_start;
    ctrl.step  = do_step;
    ctrl.op    = do_start ? opcode_e'(opcode_i) : op_q;
    ctrl.cin   = c_q;
  end

  awsf_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (do_start ? W'(operand_a_i) : a_q),
    .b_i    (do_start ? W'(operand_b_i) : b_q),
    .sum_o  (sum),
    .carry_o(add_carry),
    .prod_o (prod),
    .quo_o  (quo)
  );

  awsf_shift #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_shift (
    .op_i    (op_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .cin_i   (c_q),
    .result_o(sh_res)
  );

  always_comb begin
    new_c = c_q;
    case (op_q)
      OP_ADD: begin
        res   = sum;
        new_c = add_carry;
      end
      OP_ADC: res = sum;
      OP_SUB: begin
        res   = sum;
        new_c = add_carry;
      end
      OP_SBC: res = sum;
      OP_MUL: res = prod;
      // divide by zero gives zero
      OP_DIV: res = (b_q == '0) ? '0 : quo;
      OP_RRX: begin
        res   = sh_res;
        new_c = a_q[0];
      end
      default: res = sh_res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= 1'b0;
      z_q         <= 1'b0;
      c_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_finish) begin
        out_valid_q <= 1'b1;
        if (upd_q) begin
          n_q <= res[W-1];
          z_q <= (res == '0);
          c_q <= new_c;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_finish) begin
      res_q <= WORD_W'(res);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_word_o  = res_q;
  assign negative_out_o = n_q;
  assign zero_out_o     = z_q;
  assign carry_out_o    = c_q;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the ALU with N, Z and C flags. Operations go
// in through a burst driver and results are checked in order against a
// predictor that keeps its own copy of the flags.
// ----------------------------------------------------------------------------

module tb_top;

  import awsf_pkg::*;

  localparam int W          = WORD_W;
  localparam int N_RANDOM   = 1300;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 60;

  typedef struct {
    opcode_e        op;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic           upd;
    logic           drain;
  } alu_item_t;

  typedef struct {
    logic [W-1:0] word;
    logic         n;
    logic         z;
    logic         c;
  } flag_result_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_e;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         in_valid_i     = 1'b0;
  logic         in_stall_o;
  logic [3:0]   opcode_i       = 4'd0;
  logic [W-1:0] operand_a_i    = '0;
  logic [W-1:0] operand_b_i    = '0;
  logic         update_flags_i = 1'b0;
  logic         out_valid_o;
  logic         out_stall_i    = 1'b0;
  logic [W-1:0] result_word_o;
  logic         negative_out_o;
  logic         zero_out_o;
  logic         carry_out_o;

  alu_with_status_flags_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .update_flags_i (update_flags_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_word_o  (result_word_o),
    .negative_out_o (negative_out_o),
    .zero_out_o     (zero_out_o),
    .carry_out_o    (carry_out_o)
  );

  always #4 clk_i = ~clk_i;

  alu_item_t    pending_ops[$];
  flag_result_t expected_results[$];
  alu_item_t    driven_op;

  // predictor copy of the status flags
  logic flag_n = 1'b0;
  logic flag_z = 1'b0;
  logic flag_c = 1'b0;

  int errors       = 0;
  int ops_in       = 0;
  int results_out  = 0;
  int flag_updates = 0;
  int queued_ops   = 0;
  int idle_cycles  = 0;
  int op_hits[16];

  function automatic flag_result_t predict_alu(alu_item_t it);
    flag_result_t res;
    logic [W:0]   sum;
    logic [7:0]   amt;
    logic [4:0]   rot;
    logic         new_c;
    amt   = it.b[7:0];
    rot   = amt[4:0];
    new_c = flag_c;
    case (it.op)
      OP_ADD: begin
        sum      = {1'b0, it.a} + {1'b0, it.b};
        res.word = sum[W-1:0];
        new_c    = sum[W];
      end
      OP_ADC: res.word = it.a + it.b + flag_c;
      OP_SUB: begin
        res.word = it.a - it.b;
        new_c    = (it.a >= it.b);
      end
      // a - b - not carry is a + ~b + carry
      OP_SBC: res.word = it.a + ~it.b + flag_c;
      OP_MUL: res.word = it.a * it.b;
      OP_DIV: res.word = (it.b == '0) ? '0 : it.a / it.b;
      OP_AND: res.word = it.a & it.b;
      OP_ORR: res.word = it.a | it.b;
      OP_EOR: res.word = it.a ^ it.b;
      OP_MVN: res.word = ~it.a;
      OP_BIC: res.word = it.a & ~it.b;
      OP_ASR: res.word = (amt >= W) ? {W{it.a[W-1]}} : W'($signed(it.a) >>> amt);
      OP_LSL: res.word = (amt >= W) ? '0 : it.a << amt;
      OP_LSR: res.word = (amt >= W) ? '0 : it.a >> amt;
      OP_ROR: res.word = (rot == 0) ? it.a : (it.a >> rot) | (it.a << (W - rot));
      OP_RRX: begin
        res.word = {flag_c, it.a[W-1:1]};
        new_c    = it.a[0];
      end
      default: res.word = '0;
    endcase
    if (it.upd) begin
      flag_n = res.word[W-1];
      flag_z = (res.word == '0);
      flag_c = new_c;
    end
    res.n = flag_n;
    res.z = flag_z;
    res.c = flag_c;
    return res;
  endfunction

  task automatic add_op(opcode_e op, logic [W-1:0] a, logic [W-1:0] b, logic upd);
    alu_item_t it;
    it.op    = op;
    it.a     = a;
    it.b     = b;
    it.upd   = upd;
    it.drain = 1'b0;
    pending_ops.push_back(it);
    queued_ops++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic add_drain();
    alu_item_t it;
    it       = '{OP_ADD, '0, '0, 1'b0, 1'b1};
    pending_ops.push_back(it);
  endtask

  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(W-1){1'b0}}};
      3:       return {1'b0, {(W-1){1'b1}}};
      4:       return 1;
      5:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // mostly amounts from zero to just past the word width, sometimes any byte
  function automatic logic [W-1:0] pick_shift();
    logic [W-1:0] b;
    b = $urandom();
    if ($urandom_range(0, 3) != 0) b[7:0] = 8'($urandom_range(0, 34));
    return b;
  endfunction

  function automatic logic [W-1:0] pick_divisor();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(1, 16);
      2:       return $urandom_range(1, 65535);
      default: return pick_word();
    endcase
  endfunction

  // sender: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    alu_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_alu(driven_op));
        ops_in++;
        op_hits[driven_op.op]++;
        if (driven_op.upd) flag_updates++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_ops[0].drain) begin
          in_valid_i <= 1'b0;
          if (expected_results.size() == 0) void'(pending_ops.pop_front());
        end else begin
          nxt            = pending_ops.pop_front();
          driven_op      <= nxt;
          opcode_i       <= nxt.op;
          operand_a_i    <= nxt.a;
          operand_b_i    <= nxt.b;
          update_flags_i <= nxt.upd;
          in_valid_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern changes mode now and then, plus long hold-offs, one at a set point
  rx_mode_e rx_mode    = RX_FREE;
  int       mode_left  = 0;
  int       hold_left  = 0;
  int       rx_cycles  = 0;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_mode     <= RX_FREE;
      mode_left   <= 0;
      hold_left   <= 0;
      rx_cycles   <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (rx_cycles == 3000 || $urandom_range(0, 4999) == 0) begin
        hold_left   <= $urandom_range(120, 200);
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= rx_mode_e'($urandom_range(0, 3));
          mode_left <= $urandom_range(10, 150);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          RX_FREE:  out_stall_i <= 1'b0;
          RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
          RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:  out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    flag_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_out++;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result 0x%08h arrived with nothing expected", result_word_o);
      end else begin
        want = expected_results.pop_front();
        if (result_word_o !== want.word) begin
          errors++;
          $error("result_word: expected 0x%08h, got 0x%08h", want.word, result_word_o);
        end
        if (negative_out_o !== want.n) begin
          errors++;
          $error("negative_out: expected %0b, got %0b", want.n, negative_out_o);
        end
        if (zero_out_o !== want.z) begin
          errors++;
          $error("zero_out: expected %0b, got %0b", want.z, zero_out_o);
        end
        if (carry_out_o !== want.c) begin
          errors++;
          $error("carry_out: expected %0b, got %0b", want.c, carry_out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    opcode_e op;
    int      kind;
    int      next_drain;
    int      hits;
    int      rand_start;
    for (int i = 0; i < 16; i++) op_hits[i] = 0;

    // directed: edges of each operation
    add_op(OP_ADD, '1, 1, 1'b1);                        // wraps to zero, carry out
    add_op(OP_ADC, '0, '0, 1'b1);                       // carry in from previous
    add_op(OP_ADD, 32'h7fff_ffff, 1, 1'b1);             // goes negative, no carry
    add_op(OP_SUB, '0, 1, 1'b1);                        // borrow
    add_op(OP_SBC, 32'h10, 32'h5, 1'b1);                // borrow taken in
    add_op(OP_SUB, 32'h1234_5678, 32'h1234_5678, 1'b1); // equal, no borrow
    add_op(OP_SBC, '0, '0, 1'b1);
    add_op(OP_MUL, '1, '1, 1'b1);
    add_op(OP_MUL, 32'h8000_0000, 2, 1'b0);
    add_op(OP_DIV, 32'hdead_beef, '0, 1'b1);            // divide by zero
    add_op(OP_DIV, '1, 1, 1'b1);
    add_op(OP_DIV, 7, '1, 1'b1);
    add_op(OP_AND, '1, 32'h0f0f_0f0f, 1'b1);
    add_op(OP_ORR, '0, '0, 1'b1);
    add_op(OP_EOR, '1, '1, 1'b1);
    add_op(OP_MVN, '0, '0, 1'b1);
    add_op(OP_BIC, '1, 32'h8000_0000, 1'b1);
    add_op(OP_ASR, 32'h8000_0000, 0, 1'b1);
    add_op(OP_ASR, 32'h8000_0001, 31, 1'b1);
    add_op(OP_ASR, 32'h8000_0000, 32'hffff_ff20, 1'b1); // amount past the width
    add_op(OP_LSL, '1, 32, 1'b1);
    add_op(OP_LSR, '1, 31, 1'b1);
    add_op(OP_ROR, 32'h0000_0001, 33, 1'b1);            // amount taken mod width
    add_op(OP_RRX, 32'h0000_0001, '0, 1'b1);
    add_op(OP_RRX, 32'h0000_0000, '0, 1'b0);            // no flag update
    add_drain();

    rand_start = queued_ops;
    next_drain = queued_ops + 300;
    while (queued_ops - rand_start < N_RANDOM) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          // multiword add or subtract chain
          op = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_SUB;
          add_op(op, pick_word(), pick_word(), 1'b1);
          repeat ($urandom_range(1, 3))
            add_op((op == OP_ADD) ? OP_ADC : OP_SBC, pick_word(), pick_word(),
                   $urandom_range(0, 4) != 0);
        end
        3: begin
          // rotate through carry chain
          add_op(OP_ADD, pick_word(), pick_word(), 1'b1);
          repeat ($urandom_range(1, 4))
            add_op(OP_RRX, pick_word(), $urandom(), $urandom_range(0, 4) != 0);
        end
        4: begin
          op = opcode_e'($urandom_range(OP_ASR, OP_ROR));
          add_op(op, pick_word(), pick_shift(), ($urandom_range(0, 1) == 0));
        end
        5: begin
          if ($urandom_range(0, 1) == 0)
            add_op(OP_DIV, pick_word(), pick_divisor(), ($urandom_range(0, 1) == 0));
          else
            add_op(OP_MUL, pick_word(), pick_word(), ($urandom_range(0, 1) == 0));
        end
        default: begin
          op = opcode_e'($urandom_range(0, 15));
          if (op inside {OP_ASR, OP_LSL, OP_LSR, OP_ROR})
            add_op(op, pick_word(), pick_shift(), ($urandom_range(0, 1) == 0));
          else
            add_op(op, pick_word(), pick_word(), ($urandom_range(0, 1) == 0));
        end
      endcase
      if (queued_ops >= next_drain) begin
        add_drain();
        next_drain += 300;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_ops.size() == 0 && !in_valid_i && expected_results.size() == 0)
           && idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    if (idle_cycles < IDLE_LIMIT) repeat (TAIL_WAIT) @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT)
      $error("no transfer for %0d cycles, %0d results still expected",
             IDLE_LIMIT, expected_results.size());

    hits = 0;
    for (int i = 0; i < 16; i++) if (op_hits[i] != 0) hits++;
    $display("run: %0d operations in, %0d results out, %0d with flag update",
             ops_in, results_out, flag_updates);
    $display("run: %0d of 16 opcodes exercised, %0d mismatches", hits, errors);
    if (idle_cycles < IDLE_LIMIT && errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
design/awsf_pkg.sv
design/awsf_unit.sv
design/awsf_shift.sv
design/alu_with_status_flags_core.sv
test/tb_top.sv
